>>> rtl/core/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMP(label, clk, rst, ante, cons)
`define ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/pctbl_pkg.sv
package pctbl_pkg;

   localparam int CELLS_DEF = 16;
   // ceil(2^76 / 5^9): divide by 1e9 as a shift by 9, then by 5^9 through this reciprocal
   localparam logic [55:0] NS_RECIP = 56'd38685626227668134;
   localparam logic [31:0] RECIP_LO = NS_RECIP[31:0];
   localparam logic [23:0] RECIP_HI = NS_RECIP[55:32];

   typedef enum logic [2:0] {
      K_CREATE  = 3'd0,
      K_DESTROY = 3'd1,
      K_CPU     = 3'd2,
      K_RX      = 3'd3,
      K_TX      = 3'd4,
      K_CHECK   = 3'd5,
      K_COMMIT  = 3'd6,
      K_RELEASE = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BUSY    = 2'd1,
      ST_NOMEM   = 2'd2,
      ST_INVALID = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_RD, S_EX, S_WAIT, S_TAKE, S_WB
   } ctl_state_type;

   typedef enum logic [3:0] {
      R_IDLE, R_MLO, R_MHI, R_SUM, R_PLL, R_PLH, R_PHL, R_PHH, R_MID, R_FIN
   } ref_state_type;

   typedef struct packed {
      logic              active;
      logic [47:0]       quota;
      logic [47:0]       used;
      logic [1:0][31:0]  cap;
      logic [1:0][31:0]  rate;
      logic [2:0][31:0]  tokens;
      logic [2:0][63:0]  last;
      logic [2:0][31:0]  viol;
   } cell_entry_type;

   typedef struct packed {
      logic        done;
      logic        sat;
      logic [34:0] quot;
   } refill_res_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      logic [31:0] r;
      r = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
      return r;
   endfunction

endpackage

>>> rtl/core/pctbl_cell_mem.sv
module pctbl_cell_mem #(
   parameter int CELLS = pctbl_pkg::CELLS_DEF,
   parameter int CW = (CELLS > 1) ? $clog2(CELLS) : 1
) (
   input  logic                      clock,
   input  logic [CW-1:0]             rd_addr,
   output pctbl_pkg::cell_entry_type rd_data,
   input  logic                      wr_en,
   input  logic [CW-1:0]             wr_addr,
   input  pctbl_pkg::cell_entry_type wr_data
);
   import pctbl_pkg::*;

   cell_entry_type mem [CELLS];
   cell_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/pctbl_refill.sv
module pctbl_refill (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [63:0]               elapsed,
   input  logic [31:0]               rate,
   output pctbl_pkg::refill_res_type res
);
   import pctbl_pkg::*;

   ref_state_type st_ff, st_in;
   logic [63:0] e_ff, e_in;
   logic [31:0] r_ff, r_in;
   logic [63:0] plo_ff, plo_in, phi_ff, phi_in;
   logic [54:0] y_ff, y_in;
   logic [63:0] pa_ff, pa_in;
   logic [55:0] pb_ff, pb_in;
   logic [54:0] pc_ff, pc_in;
   logic [46:0] pd_ff, pd_in;
   logic [57:0] mid_ff, mid_in;
   logic [34:0] q_ff, q_in;
   logic sat_ff, sat_in, done_ff, done_in;
   logic [64:0] low_sum;
   logic [31:0] top_sum;
   logic [79:0] fin_sum;

   always_comb begin
      low_sum = {1'b0, phi_ff[31:0], 32'd0} + {1'b0, plo_ff};
      top_sum = phi_ff[63:32] + {31'd0, low_sum[64]};
      fin_sum = 80'(mid_ff) + {1'b0, pd_ff, 32'd0};
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         R_IDLE: if (start) st_in = R_MLO;
         R_MLO: st_in = R_MHI;
         R_MHI: st_in = R_SUM;
         R_SUM: st_in = (top_sum != 32'd0) ? R_IDLE : R_PLL;
         R_PLL: st_in = R_PLH;
         R_PLH: st_in = R_PHL;
         R_PHL: st_in = R_PHH;
         R_PHH: st_in = R_MID;
         R_MID: st_in = R_FIN;
         R_FIN: st_in = R_IDLE;
         default: st_in = R_IDLE;
      endcase
   end

   always_comb begin
      e_in = e_ff;
      r_in = r_ff;
      plo_in = plo_ff;
      phi_in = phi_ff;
      y_in = y_ff;
      pa_in = pa_ff;
      pb_in = pb_ff;
      pc_in = pc_ff;
      pd_in = pd_ff;
      mid_in = mid_ff;
      q_in = q_ff;
      sat_in = sat_ff;
      done_in = 1'b0;
      unique case (st_ff)
         R_IDLE: begin
            if (start) begin
               e_in = elapsed;
               r_in = rate;
            end
         end
         R_MLO: plo_in = 64'(e_ff[31:0] * r_ff);
         R_MHI: phi_in = 64'(e_ff[63:32] * r_ff);
         R_SUM: begin
            sat_in = (top_sum != 32'd0);
            done_in = (top_sum != 32'd0);
            // drop the factor 2^9 of 1e9 before the reciprocal multiply
            y_in = low_sum[63:9];
         end
         R_PLL: pa_in = 64'(y_ff[31:0] * RECIP_LO);
         R_PLH: pb_in = 56'(y_ff[31:0] * RECIP_HI);
         R_PHL: pc_in = 55'(y_ff[54:32] * RECIP_LO);
         R_PHH: pd_in = 47'(y_ff[54:32] * RECIP_HI);
         R_MID: mid_in = 58'(pa_ff[63:32]) + 58'(pb_ff) + 58'(pc_ff);
         R_FIN: begin
            q_in = fin_sum[78:44];
            done_in = 1'b1;
         end
         default: done_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= R_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         done_ff <= done_in;
      end
      e_ff <= e_in;
      r_ff <= r_in;
      plo_ff <= plo_in;
      phi_ff <= phi_in;
      y_ff <= y_in;
      pa_ff <= pa_in;
      pb_ff <= pb_in;
      pc_ff <= pc_in;
      pd_ff <= pd_in;
      mid_ff <= mid_in;
      q_ff <= q_in;
      sat_ff <= sat_in;
   end

   assign res = '{done: done_ff, sat: sat_ff, quot: q_ff};

endmodule

>>> rtl/core/per_cell_token_bucket_limiter.sv
// Per-cell token bucket limiter.
// Requests enter on req_* (valid/ready); one result per request leaves on
// rsp_* (valid/ready). Each request names a cell and an operation: create,
// destroy, consume from the cpu, rx or tx bucket, or check, commit or release
// memory. Cell state lives in one table memory read, updated and written back.
// One request is processed at a time. Create, destroy, memory operations and
// out-of-range or inactive cells go from the table read straight to
// write-back; a consume whose refill time has not advanced goes through the
// token take first. A consume with elapsed time runs the refill unit: two
// 32x32 partial products, a carry merge, then a reciprocal multiply for the
// divide by 1e9 (four 32-bit partial products and two adds), ending after the
// carry merge when the product overflows 64 bits. The request port reopens in
// the same cycle that the result is presented. The result sits in an output
// register; the next request is taken while it waits, but write-back of that
// request holds until the result transfers.
// Reset clears all cells to inactive with zero usage and counters and clears
// the global throttle total; no memory sweep is needed.
`include "assert_macros.svh"
module per_cell_token_bucket_limiter #(
   parameter int CELLS = pctbl_pkg::CELLS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [7:0]  req_cell_req,
   input  logic [63:0] req_now_ns,
   input  logic [31:0] req_amount,
   input  logic [31:0] req_cpu_cap,
   input  logic [31:0] req_cpu_rate,
   input  logic [31:0] req_net_cap,
   input  logic [31:0] req_net_rate,
   input  logic [47:0] req_mem_cap,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_cpu_viol,
   output logic [31:0] rsp_net_viol,
   output logic [31:0] rsp_mem_viol,
   output logic [31:0] rsp_throttle_total
);
   import pctbl_pkg::*;

   localparam int CW = (CELLS > 1) ? $clog2(CELLS) : 1;

   ctl_state_type state_ff, state_in;
   kind_type kind_ff;
   logic [7:0] cell_ff;
   logic [63:0] now_ff;
   logic [31:0] amount_ff, cpu_cap_ff, cpu_rate_ff, net_cap_ff, net_rate_ff;
   logic [47:0] mem_cap_ff;
   cell_entry_type ent_ff, ent_in, rd_data, ent_rd;
   status_type status_ff, status_in;
   logic refuse_ff, refuse_in;
   logic [1:0] bsel_ff, bsel_in;
   logic [31:0] gtot_ff, gtot_in;
   logic [CELLS-1:0] valid_ff, valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_cpu_ff, rsp_cpu_in, rsp_net_ff, rsp_net_in;
   logic [31:0] rsp_mem_ff, rsp_mem_in, rsp_tot_ff, rsp_tot_in;

   logic [CW-1:0] cidx;
   logic in_range, accept, wb_go, mem_we;
   logic go_refill, go_take, ref_start;
   logic [63:0] elapsed;
   logic [31:0] ref_rate;
   refill_res_type ref_res;
   logic [48:0] mem_sum;
   logic [35:0] tok_sum;
   logic p_sel;

   assign cidx = cell_ff[CW-1:0];
   assign in_range = ({1'b0, cell_ff} < 9'(CELLS));
   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign wb_go = (state_ff == S_WB) && (!rsp_valid_ff || rsp_ready);
   assign mem_we = wb_go && in_range;

   pctbl_cell_mem #(.CELLS(CELLS), .CW(CW)) u_mem (
      .clock   (clock),
      .rd_addr (cidx),
      .rd_data (rd_data),
      .wr_en   (mem_we),
      .wr_addr (cidx),
      .wr_data (ent_ff)
   );

   pctbl_refill u_refill (
      .clock   (clock),
      .reset   (reset),
      .start   (ref_start),
      .elapsed (elapsed),
      .rate    (ref_rate),
      .res     (ref_res)
   );

   // never-written entries read as inactive with zero usage and counters
   always_comb begin
      ent_rd = rd_data;
      if (!valid_ff[cidx]) begin
         ent_rd.active = 1'b0;
         ent_rd.used = '0;
         ent_rd.viol = '0;
      end
   end

   always_comb begin
      bsel_in = bsel_ff;
      unique case (kind_ff)
         K_CPU: bsel_in = 2'd0;
         K_RX: bsel_in = 2'd1;
         K_TX: bsel_in = 2'd2;
         default: bsel_in = 2'd0;
      endcase
      p_sel = (bsel_in != 2'd0);
      elapsed = now_ff - ent_rd.last[bsel_in];
      ref_rate = ent_rd.rate[p_sel];
      mem_sum = {1'b0, ent_rd.used} + {17'd0, amount_ff};
      tok_sum = {4'd0, ent_ff.tokens[bsel_ff]} + {1'b0, ref_res.quot};
   end

   always_comb begin
      go_refill = 1'b0;
      go_take = 1'b0;
      if (in_range && ent_rd.active &&
          (kind_ff == K_CPU || kind_ff == K_RX || kind_ff == K_TX)) begin
         if (now_ff > ent_rd.last[bsel_in]) go_refill = 1'b1;
         else go_take = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept) state_in = S_RD;
         S_RD: state_in = S_EX;
         S_EX: begin
            priority if (go_refill) state_in = S_WAIT;
            else if (go_take) state_in = S_TAKE;
            else state_in = S_WB;
         end
         S_WAIT: if (ref_res.done) state_in = S_TAKE;
         S_TAKE: state_in = S_WB;
         S_WB: if (wb_go) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ent_in = ent_ff;
      status_in = status_ff;
      refuse_in = refuse_ff;
      valid_in = valid_ff;
      gtot_in = gtot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_cpu_in = rsp_cpu_ff;
      rsp_net_in = rsp_net_ff;
      rsp_mem_in = rsp_mem_ff;
      rsp_tot_in = rsp_tot_ff;
      ref_start = 1'b0;
      unique case (state_ff)
         S_EX: begin
            ent_in = ent_rd;
            status_in = ST_OK;
            refuse_in = 1'b0;
            ref_start = go_refill;
            if (!in_range) begin
               status_in = ST_INVALID;
            end else begin
               priority case (1'b1)
                  (kind_ff == K_CREATE): begin
                     ent_in.active = 1'b1;
                     ent_in.quota = mem_cap_ff;
                     ent_in.used = '0;
                     ent_in.viol = '0;
                     ent_in.last = {now_ff, now_ff, now_ff};
                     ent_in.cap = {net_cap_ff, cpu_cap_ff};
                     ent_in.rate = {net_rate_ff, cpu_rate_ff};
                     ent_in.tokens = {net_cap_ff, net_cap_ff, cpu_cap_ff};
                  end
                  (kind_ff == K_DESTROY): begin
                     ent_in.active = 1'b0;
                     ent_in.used = '0;
                  end
                  (!ent_rd.active): status_in = ST_INVALID;
                  (kind_ff == K_CHECK || kind_ff == K_COMMIT): begin
                     if (mem_sum > {1'b0, ent_rd.quota}) begin
                        status_in = ST_NOMEM;
                        refuse_in = 1'b1;
                        ent_in.viol[2] = sat_inc(ent_rd.viol[2]);
                     end else if (kind_ff == K_COMMIT) begin
                        ent_in.used = mem_sum[47:0];
                     end
                  end
                  (kind_ff == K_RELEASE): begin
                     if ({16'd0, amount_ff} > ent_rd.used) ent_in.used = '0;
                     else ent_in.used = ent_rd.used - {16'd0, amount_ff};
                  end
                  default: status_in = ST_OK;
               endcase
            end
         end
         S_WAIT: begin
            if (ref_res.done && (ref_res.sat || ref_res.quot != 35'd0)) begin
               // clamp to capacity, advance refill time
               if (ref_res.sat ||
                   tok_sum > {4'd0, ent_ff.cap[bsel_ff != 2'd0]}) begin
                  ent_in.tokens[bsel_ff] = ent_ff.cap[bsel_ff != 2'd0];
               end else begin
                  ent_in.tokens[bsel_ff] = tok_sum[31:0];
               end
               ent_in.last[bsel_ff] = now_ff;
            end
         end
         S_TAKE: begin
            if (ent_ff.tokens[bsel_ff] < amount_ff) begin
               status_in = ST_BUSY;
               refuse_in = 1'b1;
               ent_in.viol[bsel_ff != 2'd0] = sat_inc(ent_ff.viol[bsel_ff != 2'd0]);
            end else begin
               ent_in.tokens[bsel_ff] = ent_ff.tokens[bsel_ff] - amount_ff;
            end
         end
         S_WB: begin
            if (wb_go) begin
               gtot_in = refuse_ff ? sat_inc(gtot_ff) : gtot_ff;
               if (in_range) valid_in[cidx] = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_status_in = status_ff;
               rsp_cpu_in = in_range ? ent_ff.viol[0] : 32'd0;
               rsp_net_in = in_range ? ent_ff.viol[1] : 32'd0;
               rsp_mem_in = in_range ? ent_ff.viol[2] : 32'd0;
               rsp_tot_in = gtot_in;
            end
         end
         default: ref_start = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         gtot_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         gtot_ff <= gtot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         kind_ff <= kind_type'(req_kind);
         cell_ff <= req_cell_req;
         now_ff <= req_now_ns;
         amount_ff <= req_amount;
         cpu_cap_ff <= req_cpu_cap;
         cpu_rate_ff <= req_cpu_rate;
         net_cap_ff <= req_net_cap;
         net_rate_ff <= req_net_rate;
         mem_cap_ff <= req_mem_cap;
      end
      ent_ff <= ent_in;
      status_ff <= status_in;
      refuse_ff <= refuse_in;
      bsel_ff <= bsel_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cpu_ff <= rsp_cpu_in;
      rsp_net_ff <= rsp_net_in;
      rsp_mem_ff <= rsp_mem_in;
      rsp_tot_ff <= rsp_tot_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_cpu_viol = rsp_cpu_ff;
   assign rsp_net_viol = rsp_net_ff;
   assign rsp_mem_viol = rsp_mem_ff;
   assign rsp_throttle_total = rsp_tot_ff;

   `ASSERT_IMP(a_refill_done_in_wait, clock, reset, ref_res.done, state_ff == S_WAIT)
   `ASSERT_IMP(a_write_only_in_wb, clock, reset, mem_we, state_ff == S_WB)
   `ASSERT_NXT(a_total_monotonic, clock, reset, 1'b1, gtot_ff >= $past(gtot_ff))

endmodule

>>> sim/per_cell_token_bucket_limiter_test.sv
`timescale 1ns / 1ps
module per_cell_token_bucket_limiter_test;
   import pctbl_pkg::*;

   localparam int NCELL = CELLS_DEF;

   typedef struct {
      kind_type    kind;
      logic [7:0]  cell_no;
      logic [63:0] now;
      logic [31:0] amount;
      logic [31:0] cpu_cap;
      logic [31:0] cpu_rate;
      logic [31:0] net_cap;
      logic [31:0] net_rate;
      logic [47:0] mem_cap;
      bit          drain;
   } request_type;

   typedef struct {
      status_type  status;
      logic [31:0] cpu_viol;
      logic [31:0] net_viol;
      logic [31:0] mem_viol;
      logic [31:0] total;
   } result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_kind = '0;
   logic [7:0]  req_cell_req = '0;
   logic [63:0] req_now_ns = '0;
   logic [31:0] req_amount = '0;
   logic [31:0] req_cpu_cap = '0;
   logic [31:0] req_cpu_rate = '0;
   logic [31:0] req_net_cap = '0;
   logic [31:0] req_net_rate = '0;
   logic [47:0] req_mem_cap = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_cpu_viol;
   logic [31:0] rsp_net_viol;
   logic [31:0] rsp_mem_viol;
   logic [31:0] rsp_throttle_total;

   per_cell_token_bucket_limiter u_top (.*);

   always #4 clock = ~clock;

   // shadow of the cell table
   bit          live [NCELL];
   logic [31:0] tokens [NCELL][3];
   logic [63:0] last_ns [NCELL][3];
   logic [31:0] cap [NCELL][2];
   logic [31:0] rate [NCELL][2];
   logic [47:0] quota [NCELL];
   logic [47:0] used [NCELL];
   logic [31:0] viol [NCELL][3];
   logic [31:0] throttle;

   request_type pending_reqs[$];
   result_type  expected_results[$];
   int  errors = 0;
   int  n_sent = 0, n_checked = 0, n_busy = 0, n_nomem = 0, n_invalid = 0;
   bit  stim_done = 0;
   bit  calm = 0;
   logic [63:0] clock_ns [NCELL];

   function automatic logic [31:0] bump(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   function automatic result_type limiter_step(input request_type r);
      result_type  res;
      int          c, b, p;
      logic [95:0] prod;
      logic [95:0] add;
      logic [48:0] sum;
      res.status = ST_OK;
      c = r.cell_no;
      if (r.cell_no >= NCELL) begin
         res.status = ST_INVALID;
      end else if (r.kind == K_CREATE) begin
         live[c] = 1;
         quota[c] = r.mem_cap;
         used[c] = '0;
         for (int i = 0; i < 3; i++) begin
            viol[c][i] = '0;
            last_ns[c][i] = r.now;
         end
         cap[c][0] = r.cpu_cap;
         rate[c][0] = r.cpu_rate;
         cap[c][1] = r.net_cap;
         rate[c][1] = r.net_rate;
         tokens[c][0] = r.cpu_cap;
         tokens[c][1] = r.net_cap;
         tokens[c][2] = r.net_cap;
      end else if (r.kind == K_DESTROY) begin
         live[c] = 0;
         used[c] = '0;
      end else if (!live[c]) begin
         res.status = ST_INVALID;
      end else if (r.kind inside {K_CPU, K_RX, K_TX}) begin
         b = int'(r.kind) - int'(K_CPU);
         p = (b == 0) ? 0 : 1;
         if (r.now > last_ns[c][b]) begin
            prod = 96'(r.now - last_ns[c][b]) * 96'(rate[c][p]);
            add = prod / 96'd1000000000;
            if (add > 0) begin
               if (add + 96'(tokens[c][b]) > 96'(cap[c][p])) tokens[c][b] = cap[c][p];
               else tokens[c][b] = tokens[c][b] + add[31:0];
               last_ns[c][b] = r.now;
            end
         end
         if (tokens[c][b] < r.amount) begin
            res.status = ST_BUSY;
            viol[c][p] = bump(viol[c][p]);
            throttle = bump(throttle);
         end else begin
            tokens[c][b] = tokens[c][b] - r.amount;
         end
      end else if (r.kind inside {K_CHECK, K_COMMIT}) begin
         sum = 49'(used[c]) + 49'(r.amount);
         if (sum > 49'(quota[c])) begin
            res.status = ST_NOMEM;
            viol[c][2] = bump(viol[c][2]);
            throttle = bump(throttle);
         end else if (r.kind == K_COMMIT) begin
            used[c] = sum[47:0];
         end
      end else begin
         if (48'(r.amount) > used[c]) used[c] = '0;
         else used[c] = used[c] - 48'(r.amount);
      end
      res.cpu_viol = (r.cell_no < NCELL) ? viol[c][0] : '0;
      res.net_viol = (r.cell_no < NCELL) ? viol[c][1] : '0;
      res.mem_viol = (r.cell_no < NCELL) ? viol[c][2] : '0;
      res.total = throttle;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, n_checked);
      errors++;
   endtask

   function automatic request_type make_req(input kind_type k, input int c,
                                            input logic [63:0] t, input logic [31:0] amt);
      request_type r;
      r.kind = k;
      r.cell_no = 8'(c);
      r.now = t;
      r.amount = amt;
      r.cpu_cap = {$urandom};
      r.cpu_rate = {$urandom};
      r.net_cap = {$urandom};
      r.net_rate = {$urandom};
      r.mem_cap = 48'({$urandom, $urandom});
      r.drain = 0;
      return r;
   endfunction

   function automatic request_type make_create(input int c, input logic [63:0] t,
                                               input logic [31:0] cc, input logic [31:0] cr,
                                               input logic [31:0] nc, input logic [31:0] nr,
                                               input logic [47:0] mc);
      request_type r;
      r = make_req(K_CREATE, c, t, {$urandom});
      r.cpu_cap = cc;
      r.cpu_rate = cr;
      r.net_cap = nc;
      r.net_rate = nr;
      r.mem_cap = mc;
      return r;
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            // transfer happened at the last rising edge
         end
      end
   end

   bit accepted;
   always @(posedge clock) accepted <= req_valid && req_ready && !reset;

   always @(negedge clock) begin
      request_type r;
      bit idle;
      if (!reset && !(req_valid && !accepted)) begin
         idle = !calm && ($urandom_range(99) < 37);
         if (pending_reqs.size() == 0 || idle) begin
            req_valid <= 1'b0;
         end else if (pending_reqs[0].drain && expected_results.size() != 0) begin
            req_valid <= 1'b0;
         end else begin
            r = pending_reqs.pop_front();
            expected_results.push_back(limiter_step(r));
            n_sent++;
            req_valid <= 1'b1;
            req_kind <= r.kind;
            req_cell_req <= r.cell_no;
            req_now_ns <= r.now;
            req_amount <= r.amount;
            req_cpu_cap <= r.cpu_cap;
            req_cpu_rate <= r.cpu_rate;
            req_net_cap <= r.net_cap;
            req_net_rate <= r.net_rate;
            req_mem_cap <= r.mem_cap;
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) rsp_ready <= calm || ($urandom_range(99) >= 37);
   end

   // monitor
   always @(posedge clock) begin
      result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result status", 64'(rsp_status), 64'd0);
         end else begin
            e = expected_results.pop_front();
            if (rsp_status != e.status) report_mismatch("status", rsp_status, e.status);
            if (rsp_cpu_viol != e.cpu_viol) report_mismatch("cpu_viol", rsp_cpu_viol, e.cpu_viol);
            if (rsp_net_viol != e.net_viol) report_mismatch("net_viol", rsp_net_viol, e.net_viol);
            if (rsp_mem_viol != e.mem_viol) report_mismatch("mem_viol", rsp_mem_viol, e.mem_viol);
            if (rsp_throttle_total != e.total)
               report_mismatch("throttle_total", rsp_throttle_total, e.total);
            case (e.status)
               ST_BUSY: n_busy++;
               ST_NOMEM: n_nomem++;
               ST_INVALID: n_invalid++;
               default: ;
            endcase
            n_checked++;
         end
      end
   end

   initial begin
      request_type r;
      int c, k;
      logic [63:0] step;
      for (int i = 0; i < NCELL; i++) begin
         live[i] = 0;
         used[i] = '0;
         for (int j = 0; j < 3; j++) viol[i][j] = '0;
         clock_ns[i] = 64'd0;
      end
      throttle = '0;

      // directed: invalid on untouched cells, out of range, extremes
      pending_reqs.push_back(make_req(K_CPU, 0, 64'd10, 32'd1));
      pending_reqs.push_back(make_req(K_RELEASE, 1, 64'd0, 32'd5));
      pending_reqs.push_back(make_req(K_CREATE, 8'hFF, '1, '1));
      pending_reqs.push_back(make_req(K_DESTROY, NCELL, 64'd0, '0));
      pending_reqs.push_back(make_create(0, 64'd0, 32'd100, 32'd1000000000, 32'd50, 32'd1, 48'd1000));
      pending_reqs.push_back(make_req(K_CPU, 0, 64'd0, 32'd60));
      pending_reqs.push_back(make_req(K_CPU, 0, 64'd0, 32'd60));   // short
      pending_reqs.push_back(make_req(K_CPU, 0, 64'd30, 32'd60));  // partial refill
      pending_reqs.push_back(make_req(K_CPU, 0, '1, 32'd100));     // huge refill
      pending_reqs.push_back(make_req(K_RX, 0, 64'd5, 32'd50));
      pending_reqs.push_back(make_req(K_TX, 0, 64'd5, 32'd51));
      pending_reqs.push_back(make_req(K_RX, 0, 64'd999_999_999, 32'd1)); // no token added
      pending_reqs.push_back(make_req(K_CHECK, 0, 64'd0, 32'd1001));
      pending_reqs.push_back(make_req(K_COMMIT, 0, 64'd0, 32'd600));
      pending_reqs.push_back(make_req(K_COMMIT, 0, 64'd0, 32'd600));
      pending_reqs.push_back(make_req(K_RELEASE, 0, 64'd0, 32'd100));
      pending_reqs.push_back(make_req(K_RELEASE, 0, 64'd0, '1));
      pending_reqs.push_back(make_create(1, '1, '1, '1, '1, '1, '1));
      pending_reqs.push_back(make_req(K_TX, 1, '1, '1));
      pending_reqs.push_back(make_req(K_COMMIT, 1, '1, '1));
      pending_reqs.push_back(make_create(0, 64'd7, 32'd0, 32'd0, 32'd0, 32'd0, 48'd0));
      pending_reqs.push_back(make_req(K_CPU, 0, 64'd9, 32'd0));
      pending_reqs.push_back(make_req(K_DESTROY, 0, 64'd0, '0));
      pending_reqs.push_back(make_req(K_CHECK, 0, 64'd0, '0));
      r = make_req(K_DESTROY, 2, 64'd0, '0);
      r.drain = 1;
      pending_reqs.push_back(r);

      // random: mostly valid ops on a few cells with advancing time
      for (int n = 0; n < 1150; n++) begin
         c = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(NCELL - 1);
         k = $urandom_range(99);
         step = ($urandom_range(7) == 0) ? {$urandom, $urandom} : 64'($urandom_range(3000));
         if (c < NCELL) clock_ns[c] = clock_ns[c] + step;
         if (k < 8) begin
            r = make_create(c, (c < NCELL) ? clock_ns[c] : {$urandom, $urandom},
                            $urandom_range(4) == 0 ? {$urandom} : 32'($urandom_range(500)),
                            $urandom_range(4) == 0 ? {$urandom} : 32'($urandom_range(2000000000)),
                            $urandom_range(4) == 0 ? {$urandom} : 32'($urandom_range(500)),
                            $urandom_range(4) == 0 ? {$urandom} : 32'($urandom_range(2000000000)),
                            $urandom_range(4) == 0 ? 48'({$urandom, $urandom})
                                                   : 48'($urandom_range(5000)));
         end else if (k < 11) begin
            r = make_req(K_DESTROY, c, {$urandom, $urandom}, {$urandom});
         end else begin
            r = make_req(kind_type'($urandom_range(2, 7)), c,
                         ($urandom_range(15) == 0) ? {$urandom, $urandom}
                            : ((c < NCELL) ? clock_ns[c] : 64'd0),
                         ($urandom_range(9) == 0) ? {$urandom} : 32'($urandom_range(300)));
         end
         r.drain = (n % 300 == 299);
         pending_reqs.push_back(r);
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // quiet stretch with no idling on either side
      wait (n_sent > 500);
      calm = 1;
      wait (n_sent > 650);
      calm = 0;
      wait (pending_reqs.size() == 0 && accepted == 0 && !(req_valid));
      wait (expected_results.size() == 0);
      repeat (100) @(posedge clock);
      $display("sent %0d requests, checked %0d results", n_sent, n_checked);
      $display("refusals seen: %0d busy, %0d no memory, %0d invalid", n_busy, n_nomem,
               n_invalid);
      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   initial begin
      #5ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule
